### sv/ttvl_pkg.sv
// Shared types and constants for the word tokenizer with vocabulary lookup.
// Used by the front end, the table engine and the top level; depends on nothing.
package ttvl_pkg;

  localparam logic [1:0] CMD_TEXT  = 2'd0;
  localparam logic [1:0] CMD_VOCAB = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_TOKEN = 2'd0;
  localparam logic [1:0] ST_ADDED = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

  localparam logic [7:0] APOSTROPHE = 8'h27;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_byte;
    logic       word_end;
  } in_item_t;

  typedef struct packed {
    logic [8:0] token_id;
    logic [1:0] status;
    logic       unknown;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_LOOKUP = 2'd0,
    JOB_ENTER  = 2'd1,
    JOB_CLEAR  = 2'd2
  } job_kind_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    is_word_byte = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                   (c >= 8'h30 && c <= 8'h39) || c == APOSTROPHE || c[7];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

### sv/ttvl_front.sv
// Front end: accepts input beats, builds the pending key and its hash, and
// issues lookup, enter and clear jobs. Depends on ttvl_pkg.
module ttvl_front #(
  parameter int KEY_BYTES = 31,
  parameter int KW = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ttvl_pkg::in_item_t       in_data,
  output logic                     job_valid,
  input  logic                     job_ready,
  output ttvl_pkg::job_kind_t      job_kind,
  output logic [8*KEY_BYTES-1:0]   job_key,
  output logic [KW-1:0]            job_len,
  output logic [63:0]              job_hash,
  output logic                     job_last
);

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_MUL, S_JOB1, S_JOB2} state_t;

  state_t               state_r;
  ttvl_pkg::in_item_t   item_r;
  logic [7:0]           byte_r;
  logic [8*KEY_BYTES-1:0] key_r;
  logic [KW-1:0]        len_r;
  logic [63:0]          hash_r;
  logic [63:0]          mix_r;
  logic                 cut_r;
  logic [8*KEY_BYTES-1:0] key2_r;
  logic [63:0]          hash2_r;
  logic                 tok_r;

  logic [7:0] c_low;
  assign c_low = (item_r.char_byte >= 8'h41 && item_r.char_byte <= 8'h5a) ?
                 item_r.char_byte + 8'd32 : item_r.char_byte;

  assign in_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      len_r     <= '0;
      hash_r    <= ttvl_pkg::FNV_BASIS;
      cut_r     <= 1'b0;
      tok_r     <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (item_r.command == ttvl_pkg::CMD_CLEAR) begin
            tok_r     <= 1'b0;
            len_r     <= '0;
            hash_r    <= ttvl_pkg::FNV_BASIS;
            cut_r     <= 1'b0;
            job_kind  <= ttvl_pkg::JOB_CLEAR;
            job_last  <= 1'b1;
            job_valid <= 1'b1;
            state_r   <= S_JOB1;
          end else if (item_r.command == ttvl_pkg::CMD_VOCAB) begin
            tok_r <= 1'b0;
            if (item_r.char_byte == 8'd0) begin
              cut_r  <= 1'b1;
              mix_r  <= hash_r;
              byte_r <= 8'd0;
            end else begin
              byte_r <= item_r.char_byte;
              mix_r  <= hash_r ^ {56'd0, item_r.char_byte};
            end
            state_r <= S_MUL;
          end else if (item_r.command == ttvl_pkg::CMD_TEXT) begin
            if (item_r.char_byte != 8'd0 && ttvl_pkg::is_word_byte(item_r.char_byte)) begin
              tok_r   <= 1'b0;
              byte_r  <= c_low;
              mix_r   <= hash_r ^ {56'd0, c_low};
              state_r <= S_MUL;
            end else begin
              tok_r   <= item_r.char_byte != 8'd0 && !ttvl_pkg::is_space(item_r.char_byte);
              key2_r  <= {{(8*KEY_BYTES-8){1'b0}}, item_r.char_byte};
              hash2_r <= (ttvl_pkg::FNV_BASIS ^ {56'd0, item_r.char_byte}) *
                         ttvl_pkg::FNV_PRIME;
              state_r <= S_MUL;
              byte_r  <= 8'd0;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_MUL: begin
          if (item_r.command == ttvl_pkg::CMD_TEXT &&
              !(item_r.char_byte != 8'd0 && ttvl_pkg::is_word_byte(item_r.char_byte))) begin
            if (len_r != '0) begin
              job_kind  <= ttvl_pkg::JOB_LOOKUP;
              job_key   <= key_r;
              job_len   <= len_r;
              job_hash  <= hash_r;
              job_last  <= !tok_r;
              job_valid <= 1'b1;
              state_r   <= S_JOB1;
            end else if (tok_r) begin
              job_kind  <= ttvl_pkg::JOB_LOOKUP;
              job_key   <= key2_r;
              job_len   <= KW'(1);
              job_hash  <= hash2_r;
              job_last  <= 1'b1;
              job_valid <= 1'b1;
              tok_r     <= 1'b0;
              state_r   <= S_JOB1;
            end else begin
              state_r <= S_IDLE;
            end
            len_r  <= '0;
            hash_r <= ttvl_pkg::FNV_BASIS;
            cut_r  <= 1'b0;
          end else begin
            logic [8*KEY_BYTES-1:0] k;
            logic [KW-1:0] l;
            logic [63:0] h;
            k = key_r;
            l = len_r;
            h = hash_r;
            if (!(item_r.command == ttvl_pkg::CMD_VOCAB && item_r.char_byte == 8'd0) &&
                !cut_r && 32'(len_r) < KEY_BYTES) begin
              k[8*len_r +: 8] = byte_r;
              l = len_r + KW'(1);
              h = mix_r * ttvl_pkg::FNV_PRIME;
            end
            key_r <= k;
            if (item_r.command == ttvl_pkg::CMD_VOCAB && item_r.word_end) begin
              job_kind  <= ttvl_pkg::JOB_ENTER;
              job_key   <= k;
              job_len   <= l;
              job_hash  <= h;
              job_last  <= 1'b1;
              job_valid <= 1'b1;
              len_r     <= '0;
              hash_r    <= ttvl_pkg::FNV_BASIS;
              cut_r     <= 1'b0;
              state_r   <= S_JOB1;
            end else begin
              len_r   <= l;
              hash_r  <= h;
              state_r <= S_IDLE;
            end
          end
        end
        S_JOB1: begin
          if (job_ready) begin
            if (tok_r) begin
              job_kind <= ttvl_pkg::JOB_LOOKUP;
              job_key  <= key2_r;
              job_len  <= KW'(1);
              job_hash <= hash2_r;
              job_last <= 1'b1;
              tok_r    <= 1'b0;
              state_r  <= S_JOB2;
            end else begin
              job_valid <= 1'b0;
              state_r   <= S_IDLE;
            end
          end
        end
        S_JOB2: begin
          if (job_ready) begin
            job_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/ttvl_queue.sv
// Two-entry queue of jobs between the front end and the table engine.
// Does not use ttvl_pkg; the job width is given to it by the parameter W.
module ttvl_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_valid && rd_ready) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

### sv/ttvl_back.sv
// Table engine: probes the open-addressed slot table, compares keys, enters
// words and clears the table with a sweep. Depends on ttvl_pkg.
module ttvl_back #(
  parameter int TABLE_SLOTS = 1024,
  parameter int MAX_WORDS = 512,
  parameter int KEY_BYTES = 31,
  parameter int KW = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  ttvl_pkg::job_kind_t    job_kind,
  input  logic [8*KEY_BYTES-1:0] job_key,
  input  logic [KW-1:0]          job_len,
  input  logic [63:0]            job_hash,
  input  logic                   job_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ttvl_pkg::out_item_t    out_data
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int EW = 8 * KEY_BYTES + KW + 9;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CMP, S_OUT} state_t;

  logic [EW-1:0] ent_mem [TABLE_SLOTS];
  logic          vld_mem [TABLE_SLOTS];

  state_t               state_r;
  logic [SW-1:0]        slot_r;
  logic [SW:0]          n_r;
  logic [CW-1:0]        words_r;
  ttvl_pkg::job_kind_t  kind_r;
  logic [8*KEY_BYTES-1:0] key_r;
  logic [KW-1:0]        len_r;
  logic                 last_r;
  logic [EW-1:0]        ent_r;
  logic                 vld_r;
  ttvl_pkg::out_item_t  res_r;
  logic [8*KEY_BYTES-1:0] mask;
  logic                 match;
  logic [8:0]           id_now;

  always_comb begin
    mask = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < 32'(len_r)) mask[8*i +: 8] = 8'hff;
    end
  end
  assign match = ent_r[KW+8:9] == len_r &&
                 ((ent_r[EW-1:KW+9] ^ key_r) & mask) == '0;
  assign id_now = ent_r[8:0];
  assign job_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    ent_r <= ent_mem[slot_r];
    vld_r <= vld_mem[slot_r];
    if (state_r == S_CLR) vld_mem[slot_r] <= 1'b0;
    if (state_r == S_CMP && kind_r == ttvl_pkg::JOB_ENTER && !vld_r &&
        32'(words_r) < MAX_WORDS) begin
      ent_mem[slot_r] <= {key_r & mask, len_r, 9'(words_r)};
      vld_mem[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      slot_r    <= '0;
      words_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != S_OUT) out_valid <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          slot_r <= slot_r + SW'(1);
          if (slot_r == SW'(TABLE_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            kind_r <= job_kind;
            key_r  <= job_key;
            len_r  <= job_len;
            last_r <= job_last;
            n_r    <= '0;
            if (job_kind == ttvl_pkg::JOB_CLEAR) begin
              words_r <= '0;
              slot_r  <= '0;
              state_r <= S_CLR;
            end else if (job_kind == ttvl_pkg::JOB_ENTER && 32'(words_r) >= MAX_WORDS) begin
              res_r   <= '{token_id: 9'd0, status: ttvl_pkg::ST_FULL, unknown: 1'b0,
                           run_last: 1'b1};
              state_r <= S_OUT;
            end else begin
              slot_r  <= job_hash[SW-1:0];
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (!vld_r) begin
            if (kind_r == ttvl_pkg::JOB_ENTER) begin
              res_r   <= '{token_id: 9'(words_r), status: ttvl_pkg::ST_ADDED,
                           unknown: 1'b0, run_last: 1'b1};
              words_r <= words_r + CW'(1);
            end else begin
              res_r <= '{token_id: 9'd0, status: ttvl_pkg::ST_TOKEN,
                         unknown: 1'b1, run_last: last_r};
            end
            state_r <= S_OUT;
          end else if (match) begin
            if (kind_r == ttvl_pkg::JOB_ENTER) begin
              res_r   <= '{token_id: id_now, status: ttvl_pkg::ST_DUP,
                           unknown: 1'b0, run_last: 1'b1};
              words_r <= words_r + CW'(1);
            end else begin
              res_r <= '{token_id: id_now, status: ttvl_pkg::ST_TOKEN,
                         unknown: id_now == 9'd0, run_last: last_r};
            end
            state_r <= S_OUT;
          end else if (n_r == (SW+1)'(TABLE_SLOTS - 1)) begin
            if (kind_r == ttvl_pkg::JOB_ENTER)
              res_r <= '{token_id: 9'd0, status: ttvl_pkg::ST_FULL,
                         unknown: 1'b0, run_last: 1'b1};
            else
              res_r <= '{token_id: 9'd0, status: ttvl_pkg::ST_TOKEN,
                         unknown: 1'b1, run_last: last_r};
            state_r <= S_OUT;
          end else begin
            n_r     <= n_r + (SW+1)'(1);
            slot_r  <= slot_r + SW'(1);
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data  <= res_r;
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/text_tokenizer_vocab_lookup.sv
// Top level of the word tokenizer with vocabulary lookup.
// Depends on ttvl_pkg, ttvl_front, ttvl_queue and ttvl_back.
// A text byte that extends a word passes the idle, hash and multiply states of
// the front end. A boundary issues up to two lookups; each probes one slot at
// a time through the one read port of the slot memory. After reset and after
// each clear command all slots are swept, one per cycle, before lookups resume.
module text_tokenizer_vocab_lookup #(
  parameter int TABLE_SLOTS = 1024,
  parameter int MAX_WORDS = 512,
  parameter int KEY_BYTES = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttvl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ttvl_pkg::out_item_t out_data
);

  localparam int KW = $clog2(KEY_BYTES + 1);
  localparam int JW = 2 + 8 * KEY_BYTES + KW + 64 + 1;

  logic                   f_valid, f_ready, q_valid, q_ready;
  ttvl_pkg::job_kind_t    f_kind, q_kind;
  logic [8*KEY_BYTES-1:0] f_key, q_key;
  logic [KW-1:0]          f_len, q_len;
  logic [63:0]            f_hash, q_hash;
  logic                   f_last, q_last;
  logic [JW-1:0]          q_data;

  ttvl_front #(.KEY_BYTES(KEY_BYTES), .KW(KW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job_kind(f_kind), .job_key(f_key),
    .job_len(f_len), .job_hash(f_hash), .job_last(f_last)
  );

  ttvl_queue #(.W(JW)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_kind, f_key, f_len, f_hash, f_last}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  assign {q_kind, q_key, q_len, q_hash, q_last} = q_data;

  ttvl_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_WORDS(MAX_WORDS), .KEY_BYTES(KEY_BYTES),
              .KW(KW)) u_back (
    .clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready), .job_kind(q_kind),
    .job_key(q_key), .job_len(q_len), .job_hash(q_hash), .job_last(q_last),
    .out_valid, .out_ready, .out_data
  );

endmodule
